[rtl/psbu_pkg.sv]
// ----------------------------------------------------------------------------
// psbu_pkg: shared types and constants of the packed sample bit unpacker
//
// Holds the opcodes, status codes, encoding modes, the command and result
// records that travel between the front queue, the engine and the top level.
// ----------------------------------------------------------------------------
package psbu_pkg;

    // Default depth of the byte ring.
    localparam int STORE_BYTES_DEF = 64;

    // Command queue between the front and the engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Widths of the item and result fields.
    localparam int OP_W     = 2;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 7;
    localparam int SAMPLE_W = 64;
    localparam int STATUS_W = 2;

    // Largest bit count that a read or skip may use.
    localparam logic [COUNT_W-1:0] MAX_BITS = COUNT_W'(SAMPLE_W);

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_MODE_IDX = 1'b0;

    // Opcodes of an input beat.
    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_SKIP = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ENC = 2'd1,
        ST_SHORT   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_TWOS   = 2'd0,
        MODE_OFFSET = 2'd1,
        MODE_SIGNMAG = 2'd2,
        MODE_FLOAT  = 2'd3
    } mode_t;

    // What the engine has to do with one queued command.
    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_READ = 2'd1,
        KIND_SKIP = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_FETCH,
        ENG_CONV
    } eng_state_t;

    typedef struct packed {
        kind_t               kind;
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  nbits;
    } cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        status_t                    status;
        logic                       fully_read;
    } res_t;

endpackage

[rtl/psbu_if.sv]
// ----------------------------------------------------------------------------
// psbu_if: stream channels of the packed sample bit unpacker
//
// The item channel carries op, data_byte and bit_count; the result channel
// carries sample, status and fully_read. A beat moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface psbu_item_if;
    logic                          valid;
    logic                          ready;
    logic [psbu_pkg::OP_W-1:0]     op;
    logic [psbu_pkg::DATA_W-1:0]   data_byte;
    logic [psbu_pkg::COUNT_W-1:0]  bit_count;

    modport source (output valid, output op, output data_byte, output bit_count,
                    input ready);
    modport sink   (input valid, input op, input data_byte, input bit_count,
                    output ready);
endinterface

interface psbu_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psbu_pkg::SAMPLE_W-1:0] sample;
    logic [psbu_pkg::STATUS_W-1:0]        status;
    logic                                 fully_read;

    modport source (output valid, output sample, output status, output fully_read,
                    input ready);
    modport sink   (input valid, input sample, input status, input fully_read,
                    output ready);
endinterface

[rtl/psbu_front.sv]
// ----------------------------------------------------------------------------
// psbu_front: item intake and classification
//
// Accepts item beats, turns each into a command (push, read, skip or no-op,
// with the bit count saturated to 64) and holds it in a short queue until
// the engine takes it.
// ----------------------------------------------------------------------------
module psbu_front (
    input  logic                clk,
    input  logic                rst_n,
    psbu_item_if.sink           item,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output psbu_pkg::cmd_t      cmd
);

    psbu_pkg::cmd_t                      queue_reg [psbu_pkg::QUEUE_DEPTH];
    logic [psbu_pkg::QUEUE_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [psbu_pkg::QUEUE_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [psbu_pkg::QUEUE_CW-1:0]       fill_reg, fill_next;
    psbu_pkg::cmd_t                      cmd_in;
    logic                                push;
    logic                                pop;

    // Classify the incoming beat.
    always_comb
    begin
        cmd_in.data  = item.data_byte;
        cmd_in.nbits = (item.bit_count > psbu_pkg::MAX_BITS) ? psbu_pkg::MAX_BITS
                                                             : item.bit_count;
        if (item.op == psbu_pkg::OP_PUSH)
        begin
            cmd_in.kind = psbu_pkg::KIND_PUSH;
        end
        else if (item.op == psbu_pkg::OP_READ && item.bit_count != '0)
        begin
            cmd_in.kind = psbu_pkg::KIND_READ;
        end
        else if (item.op == psbu_pkg::OP_SKIP && item.bit_count != '0)
        begin
            cmd_in.kind = psbu_pkg::KIND_SKIP;
        end
        else
        begin
            // Unused opcode, or a read or skip of zero bits.
            cmd_in.kind = psbu_pkg::KIND_NOP;
        end
    end

    // Queue handshakes and pointer updates.
    assign item.ready = (fill_reg != psbu_pkg::QUEUE_CW'(psbu_pkg::QUEUE_DEPTH));
    assign cmd_valid  = (fill_reg != '0);
    assign cmd        = queue_reg[rd_ptr_reg];
    assign push       = item.valid & item.ready;
    assign pop        = cmd_valid & cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue entries carry payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

[rtl/psbu_engine.sv]
// ----------------------------------------------------------------------------
// psbu_engine: byte ring and bit extraction
//
// Owns the byte ring and its pointers. Pushes and rejected requests are answered
// from the idle state. A read or skip walks the ring one byte per cycle, shifting
// up to eight bits into an accumulator, then converts the sample.
// ----------------------------------------------------------------------------
module psbu_engine #(
    parameter int STORE_BYTES = psbu_pkg::STORE_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psbu_pkg::mode_t      mode,
    input  logic                 cmd_valid,
    input  psbu_pkg::cmd_t       cmd,
    output logic                 cmd_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    output psbu_pkg::res_t       res
);

    localparam int IW = $clog2(STORE_BYTES);
    localparam int CW = $clog2(STORE_BYTES + 1);
    localparam int AW = CW + 3;
    localparam int SW = psbu_pkg::SAMPLE_W;
    localparam int NW = psbu_pkg::COUNT_W;

    psbu_pkg::eng_state_t   state_reg, state_next;
    logic [IW-1:0]          rd_idx_reg, rd_idx_next;
    logic [IW-1:0]          wr_idx_reg, wr_idx_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [2:0]             off_reg, off_next;
    logic [NW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          nbits_reg, nbits_next;
    logic                   is_read_reg, is_read_next;
    logic [SW-1:0]          acc_reg, acc_next;

    logic [7:0]             mem [STORE_BYTES];
    logic [7:0]             rdata_reg;
    logic [IW-1:0]          raddr;
    logic                   mem_we;

    logic [AW-1:0]          avail;
    logic                   short_bits;
    logic                   full;
    logic [IW-1:0]          rd_idx_inc;
    logic [IW-1:0]          wr_idx_inc;

    logic [3:0]             room;
    logic [3:0]             take;
    logic [3:0]             off_sum;
    logic [7:0]             shifted;
    logic [7:0]             fresh;

    logic [5:0]             top_pos;
    logic [SW-1:0]          top;
    logic [SW-1:0]          ext;
    logic                   msb;
    logic [SW-1:0]          flipped;
    logic [SW-1:0]          conv;
    psbu_pkg::status_t      conv_status;

    // Ring pointer arithmetic; the depth need not be a power of two.
    assign rd_idx_inc = (rd_idx_reg == IW'(STORE_BYTES - 1)) ? '0 : rd_idx_reg + 1'b1;
    assign wr_idx_inc = (wr_idx_reg == IW'(STORE_BYTES - 1)) ? '0 : wr_idx_reg + 1'b1;

    // Stored bits left, and the request checks made at the start of a command.
    assign avail      = {count_reg, 3'b000} - AW'(off_reg);
    assign short_bits = AW'(cmd.nbits) > avail;
    assign full       = (count_reg == CW'(STORE_BYTES));

    // Bits taken from the current byte in the fetch state.
    assign room    = 4'd8 - {1'b0, off_reg};
    assign take    = (rem_reg < NW'(room)) ? rem_reg[3:0] : room;
    assign off_sum = {1'b0, off_reg} + take;
    assign shifted = rdata_reg << off_reg;
    assign fresh   = shifted >> (4'd8 - take);

    // Prefetch the next byte while the current one is being consumed.
    assign raddr = (state_reg == psbu_pkg::ENG_FETCH) ? rd_idx_inc : rd_idx_reg;

    // Sample conversion from the finished accumulator.
    always_comb
    begin
        top_pos     = 6'(nbits_reg - 1'b1);
        top         = SW'(1) << top_pos;
        ext         = ~SW'(0) << nbits_reg;
        msb         = acc_reg[top_pos];
        flipped     = acc_reg ^ top;
        conv        = '0;
        conv_status = psbu_pkg::ST_OK;
        if (nbits_reg == NW'(1))
        begin
            // A single bit maps 0 to +1 and 1 to -1 in every mode.
            conv = acc_reg[0] ? ~SW'(0) : SW'(1);
        end
        else
        begin
            unique case (mode)
                psbu_pkg::MODE_TWOS:
                begin
                    conv = msb ? (acc_reg | ext) : acc_reg;
                end
                psbu_pkg::MODE_OFFSET:
                begin
                    conv = msb ? flipped : (flipped | ext);
                end
                psbu_pkg::MODE_SIGNMAG:
                begin
                    conv = msb ? (SW'(0) - flipped) : acc_reg;
                end
                psbu_pkg::MODE_FLOAT:
                begin
                    conv_status = psbu_pkg::ST_BAD_ENC;
                end
                default:
                begin
                    conv_status = psbu_pkg::ST_BAD_ENC;
                end
            endcase
        end
    end

    // Command sequencing.
    always_comb
    begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        count_next     = count_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        nbits_next     = nbits_reg;
        is_read_next   = is_read_reg;
        acc_next       = acc_reg;
        mem_we         = 1'b0;
        cmd_ready      = 1'b0;
        res_valid      = 1'b0;
        res.sample     = '0;
        res.status     = psbu_pkg::ST_OK;
        res.fully_read = (count_reg == '0);

        unique case (state_reg)
            psbu_pkg::ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        psbu_pkg::KIND_PUSH:
                        begin
                            res_valid = 1'b1;
                            cmd_ready = res_ready;
                            if (full)
                            begin
                                res.status = psbu_pkg::ST_FULL;
                            end
                            else
                            begin
                                res.fully_read = 1'b0;
                                if (res_ready)
                                begin
                                    mem_we      = 1'b1;
                                    wr_idx_next = wr_idx_inc;
                                    count_next  = count_reg + 1'b1;
                                end
                            end
                        end
                        psbu_pkg::KIND_READ, psbu_pkg::KIND_SKIP:
                        begin
                            if (short_bits)
                            begin
                                res_valid  = 1'b1;
                                res.status = psbu_pkg::ST_SHORT;
                                cmd_ready  = res_ready;
                            end
                            else
                            begin
                                cmd_ready    = 1'b1;
                                rem_next     = cmd.nbits;
                                nbits_next   = cmd.nbits;
                                is_read_next = (cmd.kind == psbu_pkg::KIND_READ);
                                acc_next     = '0;
                                state_next   = psbu_pkg::ENG_FETCH;
                            end
                        end
                        psbu_pkg::KIND_NOP:
                        begin
                            res_valid = 1'b1;
                            cmd_ready = res_ready;
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                            cmd_ready = res_ready;
                        end
                    endcase
                end
            end
            psbu_pkg::ENG_FETCH:
            begin
                acc_next = (acc_reg << take) | SW'(fresh);
                rem_next = rem_reg - NW'(take);
                if (off_sum[3])
                begin
                    // The byte is used up: drop it from the ring.
                    off_next    = '0;
                    rd_idx_next = rd_idx_inc;
                    count_next  = count_reg - 1'b1;
                end
                else
                begin
                    off_next = off_sum[2:0];
                end
                if (rem_reg == NW'(take))
                begin
                    state_next = psbu_pkg::ENG_CONV;
                end
            end
            psbu_pkg::ENG_CONV:
            begin
                res_valid = 1'b1;
                if (is_read_reg)
                begin
                    res.sample = conv;
                    res.status = conv_status;
                end
                if (res_ready)
                begin
                    state_next = psbu_pkg::ENG_IDLE;
                end
            end
            default:
            begin
                state_next = psbu_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= psbu_pkg::ENG_IDLE;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
            off_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
            off_reg    <= off_next;
        end
    end

    // Working registers of the current read or skip.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        nbits_reg   <= nbits_next;
        is_read_reg <= is_read_next;
        acc_reg     <= acc_next;
    end

    // Byte ring: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx_reg] <= cmd.data;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

[rtl/packed_sample_bit_unpacker.sv]
// ----------------------------------------------------------------------------
// packed_sample_bit_unpacker: MSB-first sample unpacker over a byte ring
//
// Usage: item beats carry op (push byte, read sample, skip bits), data_byte
// and bit_count. Every item beat yields exactly one result beat with sample,
// status and fully_read, in item order. The encoding register (APB, address
// 0) selects two's complement, offset binary or sign-magnitude; write it
// only while the block is idle.
// Timing: a push, a rejected request or a no-op is answered from the engine's
// idle state. A read or skip starts in the idle state, visits the fetch state
// once per ring byte touched (up to nine for 64 bits) and ends in the convert
// state; the single read port of the ring is why bytes are fetched one at a
// time. Each result passes through the output register, and the engine sees
// an item only once the command queue has registered it.
// Reset empties the ring and the queue and sets the encoding to two's
// complement; ring contents are left as they are. When the result receiver
// stalls, the output register holds its beat, the engine waits, and the
// two-entry command queue keeps taking items until it fills.
// ----------------------------------------------------------------------------
module packed_sample_bit_unpacker #(
    parameter int STORE_BYTES = psbu_pkg::STORE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    psbu_item_if.sink                       item,
    psbu_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [psbu_pkg::PADDR_W-1:0]    paddr,
    input  logic [psbu_pkg::PDATA_W-1:0]    pwdata,
    output logic [psbu_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    psbu_pkg::mode_t    mode_reg, mode_next;
    logic               out_valid_reg, out_valid_next;
    psbu_pkg::res_t     res_reg;
    logic               cmd_valid;
    logic               cmd_ready;
    psbu_pkg::cmd_t     cmd;
    logic               res_valid;
    logic               res_ready;
    psbu_pkg::res_t     res;
    logic               reg_hit;

    // Configuration register access.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[psbu_pkg::PADDR_W-1:2] == psbu_pkg::REG_MODE_IDX);
    assign prdata  = reg_hit ? psbu_pkg::PDATA_W'(mode_reg) : '0;

    always_comb
    begin
        mode_next = mode_reg;
        if (psel && penable && pwrite && pready && reg_hit)
        begin
            mode_next = psbu_pkg::mode_t'(pwdata[1:0]);
        end
    end

    // Front: intake, classification and command queue.
    psbu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // Back: ring store and bit extraction.
    psbu_engine #(
        .STORE_BYTES (STORE_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register: takes a new beat when it is empty or when the current one leaves.
    assign res_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= psbu_pkg::MODE_TWOS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample     = res_reg.sample;
    assign result.status     = res_reg.status;
    assign result.fully_read = res_reg.fully_read;

endmodule

[rtl/psbu_checker.sv]
// ----------------------------------------------------------------------------
// psbu_checker: port-level checks of the packed sample bit unpacker
//
// Watches the result channel: a stalled beat is held, and the status codes
// agree with the sample value and the fill flag.
// ----------------------------------------------------------------------------
module psbu_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 result_valid,
    input  logic                                 result_ready,
    input  logic signed [psbu_pkg::SAMPLE_W-1:0] sample,
    input  logic [psbu_pkg::STATUS_W-1:0]        status,
    input  logic                                 fully_read
);

    // A stalled result beat stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            $stable(sample) && $stable(status) && $stable(fully_read))
        else $error("result payload changed while stalled");

    // Any error status carries a zero sample.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != psbu_pkg::ST_OK |-> sample == '0)
        else $error("error result with nonzero sample");

    // A full store cannot be fully read.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == psbu_pkg::ST_FULL |-> !fully_read)
        else $error("store full reported together with fully read");

endmodule

bind packed_sample_bit_unpacker psbu_checker u_psbu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .sample       (result.sample),
    .status       (result.status),
    .fully_read   (result.fully_read)
);

[sim/packed_sample_bit_unpacker_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_sample_bit_unpacker_test: self-checking bench of the sample unpacker
//
// Drives push, read, skip and unused op beats into the item channel and
// compares every result beat with a behavioral copy of the byte ring, bit
// pointer and sample conversion. Covers all encodings, empty and full ring,
// saturated and zero bit counts, and random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module packed_sample_bit_unpacker_test;

    localparam int RING_BYTES      = psbu_pkg::STORE_BYTES_DEF;
    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASE_ITEMS     = 235;

    // The op field leaves code 3 unused; the block treats it as a no-op.
    localparam logic [psbu_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Register index that holds nothing.
    localparam logic [psbu_pkg::PADDR_W-3:0] REG_SPARE_IDX = 1'b1;

    logic clk;
    logic rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [psbu_pkg::PADDR_W-1:0] paddr;
    logic [psbu_pkg::PDATA_W-1:0] pwdata;
    logic [psbu_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    psbu_item_if   item_ch ();
    psbu_result_if res_ch ();

    packed_sample_bit_unpacker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the ring, its pointers and the encoding register.
    logic [psbu_pkg::DATA_W-1:0] shadow_ring [RING_BYTES];
    int                          rd_ptr;
    int                          wr_ptr;
    int                          stored_bytes;
    int                          bit_pos;
    psbu_pkg::mode_t             enc_mode;

    psbu_pkg::res_t pending_results [$];
    int             error_count;
    bit             quiet;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sign extension of an n-bit field held in the low bits of a word.
    function automatic logic [psbu_pkg::SAMPLE_W-1:0] sign_fill(
        logic [psbu_pkg::SAMPLE_W-1:0] v, int n);
        if (n < psbu_pkg::SAMPLE_W && v[n-1])
            v = v | (~64'd0 << n);
        return v;
    endfunction

    function automatic int bits_left();
        return stored_bytes * 8 - bit_pos;
    endfunction

    // Applies one item to the shadow state and returns the expected result beat.
    function automatic psbu_pkg::res_t unpack_predict(
        logic [psbu_pkg::OP_W-1:0] op, logic [psbu_pkg::DATA_W-1:0] data,
        logic [psbu_pkg::COUNT_W-1:0] count);
        psbu_pkg::res_t                r;
        int                            n;
        int                            i;
        logic [psbu_pkg::SAMPLE_W-1:0] v;
        logic [psbu_pkg::SAMPLE_W-1:0] top;
        r.sample     = '0;
        r.status     = psbu_pkg::ST_OK;
        r.fully_read = 1'b0;
        n = (count > psbu_pkg::MAX_BITS) ? psbu_pkg::SAMPLE_W : int'(count);
        if (op == psbu_pkg::OP_PUSH)
        begin
            if (stored_bytes >= RING_BYTES)
                r.status = psbu_pkg::ST_FULL;
            else
            begin
                shadow_ring[wr_ptr] = data;
                wr_ptr = (wr_ptr + 1) % RING_BYTES;
                stored_bytes++;
            end
        end
        else if (op == psbu_pkg::OP_READ || op == psbu_pkg::OP_SKIP)
        begin
            if (n > bits_left())
                r.status = psbu_pkg::ST_SHORT;
            else if (n > 0)
            begin
                // Take the bits most significant first across byte edges.
                v = '0;
                for (i = 0; i < n; i++)
                begin
                    v = {v[psbu_pkg::SAMPLE_W-2:0], shadow_ring[rd_ptr][7 - bit_pos]};
                    bit_pos++;
                    if (bit_pos == 8)
                    begin
                        bit_pos = 0;
                        rd_ptr = (rd_ptr + 1) % RING_BYTES;
                        stored_bytes--;
                    end
                end
                if (op == psbu_pkg::OP_READ)
                begin
                    top = 64'd1 << (n - 1);
                    if (n == 1)
                        r.sample = v[0] ? -64'sd1 : 64'sd1;
                    else
                    begin
                        unique case (enc_mode)
                            psbu_pkg::MODE_TWOS:   r.sample = sign_fill(v, n);
                            psbu_pkg::MODE_OFFSET: r.sample = sign_fill(v ^ top, n);
                            psbu_pkg::MODE_SIGNMAG:
                            begin
                                if ((v & top) != 0)
                                    r.sample = 64'd0 - (v - top);
                                else
                                    r.sample = v;
                            end
                            default:     r.status = psbu_pkg::ST_BAD_ENC;
                        endcase
                    end
                end
            end
        end
        r.fully_read = (stored_bytes == 0);
        return r;
    endfunction

    // Sends one item beat; valid stays high into the next item when no gap is drawn.
    task automatic send_item(logic [psbu_pkg::OP_W-1:0] op,
                             logic [psbu_pkg::DATA_W-1:0] data,
                             logic [psbu_pkg::COUNT_W-1:0] count);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.op        <= op;
        item_ch.data_byte <= data;
        item_ch.bit_count <= count;
        do
            @(posedge clk);
        while (!item_ch.ready);
        pending_results.push_back(unpack_predict(op, data, count));
    endtask

    // Waits until every result is back and the engine has gone quiet.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [psbu_pkg::PADDR_W-3:0] index,
                             logic [psbu_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == psbu_pkg::REG_MODE_IDX)
            enc_mode = psbu_pkg::mode_t'(value[1:0]);
    endtask

    // Bit counts lean toward short samples, with full width and out-of-range values mixed in.
    function automatic logic [psbu_pkg::COUNT_W-1:0] draw_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        else if (r < 7)
            return psbu_pkg::COUNT_W'($urandom_range(65, 127));
        else if (r < 15)
            return psbu_pkg::MAX_BITS;
        else if (r < 55)
            return psbu_pkg::COUNT_W'($urandom_range(1, 12));
        else
            return psbu_pkg::COUNT_W'($urandom_range(1, 64));
    endfunction

    // Fills the ring to the brim and pushes past it.
    task automatic fill_ring();
        while (stored_bytes < RING_BYTES)
            send_item(psbu_pkg::OP_PUSH, psbu_pkg::DATA_W'($urandom_range(0, 255)),
                      draw_count());
        repeat (2)
            send_item(psbu_pkg::OP_PUSH, psbu_pkg::DATA_W'($urandom_range(0, 255)),
                      draw_count());
    endtask

    // Consumes every stored bit, then asks for one more.
    task automatic drain_ring();
        int n;
        while (bits_left() > 0)
        begin
            n = $urandom_range(1, 64);
            if (n > bits_left())
                n = bits_left();
            send_item($urandom_range(0, 1) ? psbu_pkg::OP_READ : psbu_pkg::OP_SKIP,
                      psbu_pkg::DATA_W'($urandom_range(0, 255)), psbu_pkg::COUNT_W'(n));
        end
        send_item(psbu_pkg::OP_READ, 8'h00, psbu_pkg::COUNT_W'($urandom_range(1, 64)));
    endtask

    task automatic random_traffic(int items);
        int i;
        int r;
        for (i = 0; i < items; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (i == items / 2)
            begin
                fill_ring();
                drain_ring();
            end
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(OP_UNUSED, psbu_pkg::DATA_W'($urandom_range(0, 255)),
                          draw_count());
            else if (r < 48)
                send_item(psbu_pkg::OP_PUSH, psbu_pkg::DATA_W'($urandom_range(0, 255)),
                          draw_count());
            else if (r < 85)
                send_item(psbu_pkg::OP_READ, psbu_pkg::DATA_W'($urandom_range(0, 255)),
                          draw_count());
            else
                send_item(psbu_pkg::OP_SKIP, psbu_pkg::DATA_W'($urandom_range(0, 255)),
                          draw_count());
        end
    endtask

    // Requests against an empty ring right after reset.
    task automatic test_empty_ring();
        send_item(psbu_pkg::OP_READ, 8'h00, 7'd1);
        send_item(psbu_pkg::OP_SKIP, 8'hFF, 7'd5);
        send_item(OP_UNUSED, 8'hFF, 7'd127);
        send_item(psbu_pkg::OP_READ, 8'h00, 7'd0);
    endtask

    // Byte extremes, one-bit samples, saturated count and a short request.
    task automatic test_bit_walk();
        logic [psbu_pkg::DATA_W-1:0] walk [10];
        int i;
        walk = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'hFE, 8'hC3, 8'h3C};
        for (i = 0; i < 10; i++)
            send_item(psbu_pkg::OP_PUSH, walk[i], 7'd0);
        send_item(psbu_pkg::OP_READ, 8'h00, 7'd1);
        send_item(psbu_pkg::OP_READ, 8'h00, 7'd1);
        send_item(psbu_pkg::OP_SKIP, 8'h00, 7'd0);
        send_item(psbu_pkg::OP_READ, 8'h00, 7'd127);
        send_item(psbu_pkg::OP_READ, 8'h00, 7'd14);
        send_item(psbu_pkg::OP_SKIP, 8'h00, 7'd12);
        send_item(psbu_pkg::OP_READ, 8'h00, 7'd64);
    endtask

    task automatic test_encoding(psbu_pkg::mode_t mode);
        wait_idle();
        apb_write(psbu_pkg::REG_MODE_IDX, psbu_pkg::PDATA_W'(mode));
        random_traffic(PHASE_ITEMS);
    endtask

    // A write to the spare register index must leave the encoding alone.
    task automatic test_spare_register();
        wait_idle();
        apb_write(REG_SPARE_IDX, '1);
        random_traffic(60);
    endtask

    // Result channel: random stalls, then each beat is compared with the oldest expectation.
    initial
    begin
        psbu_pkg::res_t exp_res;
        int             stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with no expectation: sample %0d status %0d",
                         $time, res_ch.sample, res_ch.status);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (res_ch.sample !== exp_res.sample)
                begin
                    $display("%0t: sample mismatch: expected %0d, actual %0d",
                             $time, exp_res.sample, res_ch.sample);
                    error_count++;
                end
                if (res_ch.status !== exp_res.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_res.status, res_ch.status);
                    error_count++;
                end
                if (res_ch.fully_read !== exp_res.fully_read)
                begin
                    $display("%0t: fully_read mismatch: expected %0d, actual %0d",
                             $time, exp_res.fully_read, res_ch.fully_read);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without a beat on either channel.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                $display("FAIL packed_sample_bit_unpacker");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        psbu_pkg::mode_t spread_mode;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_ch.valid     = 1'b0;
        item_ch.op        = psbu_pkg::OP_PUSH;
        item_ch.data_byte = '0;
        item_ch.bit_count = '0;
        rd_ptr            = 0;
        wr_ptr            = 0;
        stored_bytes      = 0;
        bit_pos           = 0;
        enc_mode          = psbu_pkg::MODE_TWOS;
        error_count       = 0;
        quiet             = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_bit_walk();
        test_encoding(psbu_pkg::MODE_TWOS);
        test_encoding(psbu_pkg::MODE_OFFSET);
        test_encoding(psbu_pkg::MODE_SIGNMAG);
        test_encoding(psbu_pkg::MODE_FLOAT);
        test_spare_register();
        spread_mode = psbu_pkg::mode_t'($urandom_range(0, 3));
        test_encoding(spread_mode);

        wait_idle();
        if (error_count == 0)
            $display("PASS packed_sample_bit_unpacker");
        else
            $display("FAIL packed_sample_bit_unpacker");
        $finish;
    end

endmodule
